FILE: hw/rtl/pidx_pkg.sv
// Shared types, constants and helper functions for the packed index unpacker.
// Used by pidx_front, pidx_back and packed_index_unpacker_core; no dependencies.

package pidx_pkg;

    localparam int PIDX_SIDE_DEFAULT   = 16;
    localparam int PIDX_QDEPTH_DEFAULT = 2;

    localparam int WORD_W  = 64;
    localparam int IDX_W   = 12;
    localparam int PAL_W   = 13;
    localparam int COORD_W = 4;
    localparam int ENTRY_W = 13;
    localparam int CNT_W   = 4;
    localparam int POS_W   = 7;
    localparam int CARRY_W = IDX_W - 1;
    localparam int OUT_W   = IDX_W + 3 * COORD_W;

    localparam logic [PAL_W-1:0] MAX_PALETTE = 13'd4096;

    // One input word together with its end-of-section flag.
    typedef struct packed {
        logic              fin;
        logic [WORD_W-1:0] word;
    } t_word_item;

    // Observation of the back end's control state.
    typedef struct packed {
        logic               busy;
        logic [ENTRY_W-1:0] entry;
        logic [CNT_W-1:0]   carry_cnt;
        logic [CNT_W-1:0]   width;
    } t_back_status;

    function automatic logic [PAL_W-1:0] eff_palette(input logic [PAL_W-1:0] ps);
        return (ps > MAX_PALETTE) ? MAX_PALETTE : ps;
    endfunction

    // Smallest width of at least one bit whose range covers the palette.
    function automatic logic [CNT_W-1:0] field_width(input logic [PAL_W-1:0] ps);
        logic [PAL_W-1:0] eff;
        logic [CNT_W-1:0] w;
        eff = eff_palette(ps);
        w   = CNT_W'(1);
        for (int k = 1; k < IDX_W; k++) begin
            if ((PAL_W'(1) << k) < eff) begin
                w = CNT_W'(k + 1);
            end
        end
        return w;
    endfunction

endpackage

FILE: hw/rtl/pidx_front.sv
// Front end of the packed index unpacker: accepts words and queues them.
// Depends on pidx_pkg for the queued item type.

module pidx_front
    import pidx_pkg::*;
#(
    parameter int QDEPTH = PIDX_QDEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,  // word
    input  logic       s_axis_tlast,
    output t_word_item o_item,
    output logic       o_item_valid,
    input  logic       i_item_ready
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(QDEPTH);

    t_word_item r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_QW-1:0] r_count, n_count;
    logic push, pop;

    assign s_axis_tready = (r_count != CNT_FULL);
    assign o_item_valid  = (r_count != '0);
    assign o_item        = r_mem[r_rd];

    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = o_item_valid && i_item_ready;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   n_count = r_count + CNT_QW'(1);
            2'b01:   n_count = r_count - CNT_QW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{fin: s_axis_tlast, word: s_axis_tdata};
        end
    end

endmodule

FILE: hw/rtl/pidx_back.sv
// Back end of the packed index unpacker: slices one queued word into indices,
// one per cycle while the result register is free, and drives that register. Depends on pidx_pkg.

module pidx_back
    import pidx_pkg::*;
#(
    parameter int SIDE = PIDX_SIDE_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PAL_W-1:0]   i_cfg_wdata,
    input  t_word_item         i_item,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [OUT_W-1:0]   o_m_tdata,  // index, pos_x, pos_y, pos_z
    output logic               o_m_tlast,
    output logic [0:0]         o_m_tuser,  // section_done
    output t_back_status       o_status
);

    localparam logic [ENTRY_W-1:0] TOTAL   = ENTRY_W'(SIDE * SIDE * SIDE);
    localparam logic [COORD_W-1:0] SIDE_M1 = COORD_W'(SIDE - 1);
    localparam logic [POS_W:0]     WORD_END = (POS_W + 1)'(WORD_W);

    // Control state.
    logic               r_busy, n_busy;
    logic               r_comb, n_comb;
    logic [POS_W-1:0]   r_p, n_p;
    logic [CARRY_W-1:0] r_carry, n_carry;
    logic [CNT_W-1:0]   r_cc, n_cc;
    logic [ENTRY_W-1:0] r_entry, n_entry;
    logic [COORD_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [PAL_W-1:0]   r_palette, n_palette;
    logic [CNT_W-1:0]   r_width, n_width;
    logic               r_m_valid, n_m_valid;

    // Payload.
    logic [WORD_W-1:0]  r_word, n_word;
    logic               r_fin, n_fin;
    logic [OUT_W-1:0]   r_m_data, n_m_data;
    logic               r_m_last, n_m_last;
    logic               r_m_done, n_m_done;

    logic               full, out_free, emit, has_next;
    logic [IDX_W-1:0]   ext, ext_sh, raw, mask, masked, clamped;
    logic [POS_W-1:0]   p_next;
    logic [POS_W:0]     pw, pnw;
    logic [ENTRY_W-1:0] entry_next;
    logic [CARRY_W-1:0] tail;
    logic [PAL_W-1:0]   eff;
    logic [COORD_W-1:0] x_adv, y_adv, z_adv;

    assign o_item_ready = !r_busy && !i_cfg_we;
    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_data;
    assign o_m_tlast    = r_m_last;
    assign o_m_tuser    = r_m_done;
    assign o_status     = '{busy: r_busy, entry: r_entry, carry_cnt: r_cc, width: r_width};

    // Datapath of one slicing step.
    always_comb begin
        full     = (r_entry >= TOTAL);
        out_free = !r_m_valid || i_m_tready;
        ext      = IDX_W'(r_word >> r_p);
        ext_sh   = ext << r_cc;
        mask     = IDX_W'((IDX_W + 1)'(1) << r_width) - IDX_W'(1);
        eff      = eff_palette(r_palette);
        pw       = {1'b0, r_p} + (POS_W + 1)'(r_width);

        // The first index of a word joins the bits left over from the previous one.
        if (r_comb) begin
            raw    = IDX_W'(r_carry) | ext_sh;
            p_next = POS_W'(r_width - r_cc);
        end else if (pw <= WORD_END) begin
            raw    = ext;
            p_next = POS_W'(pw);
        end else begin
            raw    = ext;
            p_next = POS_W'(WORD_W);
        end

        masked     = raw & mask;
        clamped    = ({1'b0, masked} >= eff) ? '0 : masked;
        entry_next = r_entry + ENTRY_W'(1);
        pnw        = {1'b0, p_next} + (POS_W + 1)'(r_width);
        has_next   = (entry_next < TOTAL) &&
                     ((pnw <= WORD_END) || (r_fin && ({1'b0, p_next} < WORD_END)));
        tail       = CARRY_W'(r_word >> p_next);

        x_adv = r_x + COORD_W'(1);
        z_adv = r_z;
        y_adv = r_y;
        if (r_x == SIDE_M1) begin
            x_adv = '0;
            z_adv = r_z + COORD_W'(1);
            if (r_z == SIDE_M1) begin
                z_adv = '0;
                y_adv = r_y + COORD_W'(1);
            end
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_comb    = r_comb;
        n_p       = r_p;
        n_carry   = r_carry;
        n_cc      = r_cc;
        n_entry   = r_entry;
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_palette = r_palette;
        n_width   = r_width;
        n_word    = r_word;
        n_fin     = r_fin;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        n_m_done  = r_m_done;
        emit      = 1'b0;

        if (i_cfg_we) begin
            n_palette = i_cfg_wdata;
            n_width   = field_width(i_cfg_wdata);
            n_carry   = '0;
            n_cc      = '0;
            n_entry   = '0;
            n_x       = '0;
            n_y       = '0;
            n_z       = '0;
        end else if (r_busy) begin
            if (full) begin
                // A full section drops the word and only waits for its end.
                n_busy  = 1'b0;
                n_carry = '0;
                n_cc    = '0;
                if (r_fin) begin
                    n_entry = '0;
                    n_x     = '0;
                    n_y     = '0;
                    n_z     = '0;
                end
            end else if (out_free) begin
                emit      = 1'b1;
                n_m_valid = 1'b1;
                n_m_data  = {r_z, r_y, r_x, clamped};
                n_m_last  = !has_next;
                n_m_done  = (entry_next >= TOTAL) || (!has_next && r_fin);
                n_entry   = entry_next;
                n_x       = x_adv;
                n_y       = y_adv;
                n_z       = z_adv;
                n_p       = p_next;
                n_comb    = 1'b0;
                if (!has_next) begin
                    n_busy = 1'b0;
                    if (r_fin) begin
                        n_carry = '0;
                        n_cc    = '0;
                        n_entry = '0;
                        n_x     = '0;
                        n_y     = '0;
                        n_z     = '0;
                    end else if ((entry_next < TOTAL) && ({1'b0, p_next} < WORD_END)) begin
                        n_carry = tail;
                        n_cc    = CNT_W'(WORD_END - {1'b0, p_next});
                    end else begin
                        n_carry = '0;
                        n_cc    = '0;
                    end
                end
            end
        end else if (i_item_valid) begin
            n_busy = 1'b1;
            n_word = i_item.word;
            n_fin  = i_item.fin;
            n_p    = '0;
            n_comb = (r_cc != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_comb    <= 1'b0;
            r_p       <= '0;
            r_carry   <= '0;
            r_cc      <= '0;
            r_entry   <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_z       <= '0;
            r_palette <= PAL_W'(1);
            r_width   <= CNT_W'(1);
            r_m_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_comb    <= n_comb;
            r_p       <= n_p;
            r_carry   <= n_carry;
            r_cc      <= n_cc;
            r_entry   <= n_entry;
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_palette <= n_palette;
            r_width   <= n_width;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_fin  <= n_fin;
        if (emit) begin
            r_m_data <= n_m_data;
            r_m_last <= n_m_last;
            r_m_done <= n_m_done;
        end
    end

endmodule

FILE: hw/rtl/packed_index_unpacker_core.sv
// Packed index unpacker, top level: word queue in front, slicing engine behind.
// The first index of a word passes the word queue, the engine's word register and the result register.
// The engine loads a word, then emits each index it completes, and takes no new word until it is through;
// while the receiver is ready, the slicing engine emits one index a cycle.
// A word arriving once the section is full is loaded and dropped, and yields nothing.
// Reset clears the queue and all section state and sets the palette size to one.

module packed_index_unpacker_core
    import pidx_pkg::*;
#(
    parameter int SIDE   = PIDX_SIDE_DEFAULT,
    parameter int QDEPTH = PIDX_QDEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [PAL_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,  // word
    input  logic              s_axis_tlast,  // last_word
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,  // index[11:0], pos_x, pos_y, pos_z
    output logic              m_axis_tlast,  // last
    output logic [0:0]        m_axis_tuser   // section_done
);

    localparam logic [ENTRY_W-1:0] TOTAL = ENTRY_W'(SIDE * SIDE * SIDE);

    t_word_item   item;
    logic         item_valid, item_ready;
    t_back_status status;

    pidx_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_item        (item),
        .o_item_valid  (item_valid),
        .i_item_ready  (item_ready)
    );

    pidx_back #(
        .SIDE (SIDE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .o_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_m_tdata    (m_axis_tdata),
        .o_m_tlast    (m_axis_tlast),
        .o_m_tuser    (m_axis_tuser),
        .o_status     (status)
    );

    // A result that completes the section is always the final one of its word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("section_done without last");

    // The entry count never runs past the section size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.entry <= TOTAL)
        else $error("entry count beyond section size");

    // Leftover bits never make up a whole index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.carry_cnt < status.width)
        else $error("carry holds a complete index");

    // A configuration write starts a fresh section.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (status.entry == '0) && (status.carry_cnt == '0))
        else $error("section state not cleared by configuration");

endmodule

FILE: dv/tb_packed_index_unpacker_core.sv
// Self-checking testbench for packed_index_unpacker_core: streams packed words in, predicts
// every decoded index with its coordinates and compares it with each word the block emits.
// Depends on pidx_pkg and packed_index_unpacker_core only.
`timescale 1ns / 1ps

module tb_packed_index_unpacker_core;
    import pidx_pkg::*;

    localparam int SIDE            = PIDX_SIDE_DEFAULT;
    localparam int SECTION_ENTRIES = SIDE * SIDE * SIDE;
    localparam int RANDOM_WORDS    = 24;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic               last;
        logic               section_done;
    } t_decoded;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [PAL_W-1:0]   i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [WORD_W-1:0]  s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;
    logic [0:0]         m_axis_tuser;

    packed_index_unpacker_core #(
        .SIDE (SIDE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state, mirroring the section state of the block.
    logic [PAL_W-1:0]  pal_size;
    logic [WORD_W-1:0] carry_bits;
    int                carry_cnt;
    int                entry_cnt;

    t_decoded   expected_indices[$];
    t_decoded   word_indices[$];
    t_word_item pending_words[$];

    bit idle_on = 1'b1;
    int src_gap = 0;
    int sink_gap = 0;
    int words_accepted = 0;
    int indices_checked = 0;
    int palettes_written = 0;
    int mismatches = 0;
    int cycle_count = 0;

    function automatic int clamp_limit();
        return (pal_size > 13'd4096) ? 4096 : int'(pal_size);
    endfunction

    function automatic int index_width();
        int w;
        w = 1;
        while (w < IDX_W && (1 << w) < clamp_limit()) begin
            w++;
        end
        return w;
    endfunction

    task automatic emit_index(input logic [WORD_W-1:0] raw);
        t_decoded r;
        r.index        = (raw >= WORD_W'(clamp_limit())) ? '0 : raw[IDX_W-1:0];
        r.pos_x        = COORD_W'(entry_cnt % SIDE);
        r.pos_y        = COORD_W'(entry_cnt / (SIDE * SIDE));
        r.pos_z        = COORD_W'((entry_cnt / SIDE) % SIDE);
        r.last         = 1'b0;
        entry_cnt      = entry_cnt + 1;
        r.section_done = (entry_cnt >= SECTION_ENTRIES);
        word_indices.push_back(r);
    endtask

    // Works out every index that one accepted word completes.
    task automatic unpack_word(input logic [WORD_W-1:0] data, input logic fin);
        int                w;
        int                p;
        logic [WORD_W-1:0] mask;
        t_decoded          r;
        w    = index_width();
        mask = (WORD_W'(1) << w) - WORD_W'(1);
        p    = 0;
        word_indices.delete();
        if (entry_cnt < SECTION_ENTRIES) begin
            // An index straddling the word boundary is finished first.
            if (carry_cnt > 0 && carry_cnt < w) begin
                emit_index((carry_bits | (data << carry_cnt)) & mask);
                p = w - carry_cnt;
            end
            while (entry_cnt < SECTION_ENTRIES && p + w <= WORD_W) begin
                emit_index((data >> p) & mask);
                p += w;
            end
            if (entry_cnt < SECTION_ENTRIES && p < WORD_W) begin
                carry_bits = data >> p;
                carry_cnt  = WORD_W - p;
            end else begin
                carry_bits = '0;
                carry_cnt  = 0;
            end
            if (fin && carry_cnt > 0 && entry_cnt < SECTION_ENTRIES) begin
                emit_index(carry_bits & mask);
            end
        end else begin
            carry_bits = '0;
            carry_cnt  = 0;
        end
        if (word_indices.size() > 0) begin
            r      = word_indices.pop_back();
            r.last = 1'b1;
            if (fin) begin
                r.section_done = 1'b1;
            end
            word_indices.push_back(r);
        end
        if (fin) begin
            carry_bits = '0;
            carry_cnt  = 0;
            entry_cnt  = 0;
        end
        foreach (word_indices[k]) begin
            expected_indices.push_back(word_indices[k]);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Word driver.
    always @(posedge i_clk) begin : drive_words
        t_word_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                unpack_word(s_axis_tdata, s_axis_tlast);
                words_accepted++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    item = pending_words.pop_front();
                    s_axis_tdata  <= item.word;
                    s_axis_tlast  <= item.fin;
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0) begin
                        src_gap = $urandom_range(1, 7);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge i_clk) begin : watch_indices
        t_decoded want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_indices.size() == 0) begin
                    $error("unexpected index word: tdata=%h tlast=%b tuser=%b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_indices.pop_front();
                    check_field("index", want.index, m_axis_tdata[11:0]);
                    check_field("pos_x", want.pos_x, m_axis_tdata[15:12]);
                    check_field("pos_y", want.pos_y, m_axis_tdata[19:16]);
                    check_field("pos_z", want.pos_z, m_axis_tdata[23:20]);
                    check_field("last", want.last, m_axis_tlast);
                    check_field("section_done", want.section_done, m_axis_tuser[0]);
                    indices_checked++;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) begin
                    sink_gap = $urandom_range(1, 7);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d indices outstanding",
                     cycle_count, expected_indices.size());
            $display("FAIL packed_index_unpacker_core");
            $finish;
        end
    end

    task automatic queue_word(input logic [WORD_W-1:0] data, input logic fin);
        t_word_item item;
        item.word = data;
        item.fin  = fin;
        pending_words.push_back(item);
    endtask

    // Waits until every queued word is taken and every index has arrived.
    task automatic wait_drained(input int settle);
        do begin
            @(negedge i_clk);
        end while (pending_words.size() > 0 || s_axis_tvalid || expected_indices.size() > 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // The write also starts a new section, so it is only made while the block is idle.
    task automatic write_palette(input int ps);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= PAL_W'(ps);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pal_size   = PAL_W'(ps);
        carry_bits = '0;
        carry_cnt  = 0;
        entry_cnt  = 0;
        palettes_written++;
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic int random_palette();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 17);
            1:       return 4096;
            2:       return $urandom_range(4097, 8191);
            3:       return (1 << $urandom_range(1, 12)) + $urandom_range(0, 2) - 1;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    initial begin
        int  n_words;
        int  pause_at;
        int  random_words;
        int  fill_words;
        bit  broken;
        pal_size   = PAL_W'(1);
        carry_bits = '0;
        carry_cnt  = 0;
        entry_cnt  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Palette size of one after reset: every index decodes as zero.
        queue_word('1, 1'b0);
        queue_word('0, 1'b1);
        wait_drained(DRAIN_CYCLES);

        // Palette size zero, in a section of a single word.
        write_palette(0);
        queue_word(64'h0123_4567_89AB_CDEF, 1'b1);
        wait_drained(DRAIN_CYCLES);

        // Three-bit indices straddle words and some exceed the palette; the sender
        // holds off mid-section until every index has come out.
        write_palette(5);
        queue_word('1, 1'b0);
        queue_word('0, 1'b0);
        wait_drained(0);
        queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        wait_drained(DRAIN_CYCLES);

        write_palette(4096);
        queue_word('1, 1'b0);
        queue_word(64'h5555_5555_5555_5555, 1'b0);
        queue_word(random_word(), 1'b1);
        wait_drained(DRAIN_CYCLES);

        write_palette(8191);
        queue_word('1, 1'b0);
        queue_word('1, 1'b1);
        wait_drained(DRAIN_CYCLES);

        write_palette(4097);
        queue_word(64'hFFF0_0FFF_F00F_0FF0, 1'b1);
        wait_drained(DRAIN_CYCLES);

        write_palette(2048);
        queue_word('1, 1'b0);
        queue_word(64'h8000_0000_0000_0001, 1'b1);
        wait_drained(DRAIN_CYCLES);

        // Two-bit indices fill the word exactly, so no partial index at the end.
        write_palette(3);
        queue_word('1, 1'b0);
        queue_word(random_word(), 1'b1);
        wait_drained(DRAIN_CYCLES);

        // A register write drops the carried bits of an unfinished section.
        write_palette(6);
        queue_word('1, 1'b0);
        wait_drained(DRAIN_CYCLES);
        write_palette(6);
        queue_word(random_word(), 1'b1);
        wait_drained(DRAIN_CYCLES);

        // One-bit indices fill the section; words after that yield nothing.
        write_palette(2);
        fill_words = SECTION_ENTRIES / 64 + $urandom_range(0, 2);
        for (int k = 0; k < fill_words; k++) begin
            queue_word(random_word(), k == fill_words - 1);
        end
        wait_drained(DRAIN_CYCLES);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            idle_on = (RANDOM_WORDS - random_words > 15) ? ($urandom_range(0, 3) != 0) : 1'b0;
            write_palette(random_palette());
            repeat ($urandom_range(1, 3)) begin
                n_words  = $urandom_range(1, 8);
                broken   = ($urandom_range(0, 5) == 0);
                pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_words - 1) : -1;
                for (int k = 0; k < n_words; k++) begin
                    if (k == pause_at) begin
                        wait_drained(0);
                    end
                    queue_word(random_word(), !broken && k == n_words - 1);
                end
                random_words += n_words;
            end
            wait_drained(DRAIN_CYCLES);
        end

        wait_drained(DRAIN_CYCLES);
        $display("Run covered %0d words over %0d palette settings; %0d indices checked.",
                 words_accepted, palettes_written, indices_checked);
        if (mismatches == 0) begin
            $display("PASS packed_index_unpacker_core");
        end else begin
            $display("FAIL packed_index_unpacker_core");
        end
        $finish;
    end

endmodule
